/* hw/rtl/xxh_pkg.sv */
// xxh_pkg: constants, sequencer states, multiplier request/response types and helper functions for the xxh64 block
// no dependencies; used by xxh_mul64 and xxh64_stream_hash_top
package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_A,
    ST_R_B,
    ST_FIN,
    ST_MSUM,
    ST_M_A,
    ST_M_B,
    ST_M_C,
    ST_LEN,
    ST_P_A,
    ST_P_B,
    ST_P_C,
    ST_TAIL,
    ST_T4_A,
    ST_T4_B,
    ST_T1_A,
    ST_T1_B,
    ST_AV_A,
    ST_AV_B,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mul_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
    rotl64 = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  // start value of one lane accumulator
  function automatic logic [63:0] lane_init(input logic [63:0] seed, input logic [1:0] k);
    logic [63:0] v;
    unique case (k)
      2'd0:    v = seed + PRIME1 + PRIME2;
      2'd1:    v = seed + PRIME2;
      2'd2:    v = seed;
      default: v = seed - PRIME1;
    endcase
    lane_init = v;
  endfunction

endpackage

/* hw/rtl/xxh_in_if.sv */
// xxh_in_if: input channel of the xxh64 block, valid/ready with one message word
// no dependencies
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_item;

  modport source(output valid, data_word, byte_count, last_item, input ready);
  modport sink(input valid, data_word, byte_count, last_item, output ready);
endinterface

/* hw/rtl/xxh_out_if.sv */
// xxh_out_if: result channel of the xxh64 block, valid/ready with one hash
// no dependencies
interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

/* hw/rtl/xxh_mul64.sv */
// xxh_mul64: 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle
// depends on xxh_pkg (mul_req_t, mul_rsp_t)
module xxh_mul64 (
  input  logic             clk,
  input  logic             rst_n,
  input  xxh_pkg::mul_req_t req,
  output xxh_pkg::mul_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [1:0]  ph_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;

  // lo*lo, hi*lo, lo*hi; cross terms only count in their low half
  assign op_x = (ph_r == 2'd1) ? a_r[63:32] : a_r[31:0];
  assign op_y = (ph_r == 2'd2) ? b_r[63:32] : b_r[31:0];
  // zero-extended halves, full 64-bit product kept
  assign prod = {32'h0, op_x} * {32'h0, op_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy_r) begin
      prod_r <= prod;
      unique case (ph_r)
        2'd0:    acc_r <= acc_r;
        2'd1:    acc_r <= prod_r;
        default: acc_r <= acc_r + {prod_r[31:0], 32'h0};
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("multiply started while one is in flight");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("multiply done while still busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ph_r == 2'd3 && !req.start) |=> done_r)
    else $error("multiply finished without done");

endmodule

/* hw/rtl/xxh64_stream_hash_top.sv */
// xxh64_stream_hash_top: streaming xxh64 hash, sequencer around one shared multiplier
// depends on xxh_pkg, xxh_in_if, xxh_out_if, xxh_mul64
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    data_word[63:0], byte_count[3:0], last_item
//  out_chan  out  valid/ready    hash_value[63:0]
//  cfg       in   cfg_we         cfg_wdata[63:0] = hash_seed
//
// every 64-bit multiply runs on xxh_mul64
// a word that does not close a stripe is buffered; one closing a stripe adds 8 multiplies
// last item: stripe rounds if it closes one; lane merge (12 multiplies) if a stripe was seen,
//   else seed start; length add; 3 multiplies per held word, 2 per tail chunk, 2 avalanche, emit
// in_chan.ready is high only while the sequencer is idle; a finished hash waits in the
// output register, and the next message can start while it is still pending
// rst_n is synchronous: seed 0, message state cleared, no hash pending
module xxh64_stream_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  xxh_in_if.sink      in_chan,
  xxh_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  xxh_pkg::seq_state_t state_r, state_nxt;

  logic [63:0] seed_r;
  logic [63:0] acc_r [0:3];
  logic [63:0] acc_nxt [0:3];
  logic [63:0] pend_r [0:2];
  logic [63:0] pend_nxt [0:2];
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [63:0] msg_len_r, msg_len_nxt;
  logic        stripe_seen_r, stripe_seen_nxt;
  logic [63:0] data_r, data_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [63:0] h_r, h_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  xxh_pkg::mul_req_t mul_req;
  xxh_pkg::mul_rsp_t mul_rsp;

  logic        in_fire;
  logic [3:0]  n_cl;
  logic        full_word;
  logic [63:0] word_next;
  logic [63:0] lane_base;
  logic [63:0] rot_res31;
  logic [63:0] hx;

  xxh_mul64 u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  assign in_chan.ready       = (state_r == xxh_pkg::ST_IDLE);
  assign in_fire             = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = out_hash_r;

  // byte counts above eight count as eight; only the last item may be short
  assign n_cl      = (in_chan.byte_count > 4'd8) ? 4'd8 : in_chan.byte_count;
  assign full_word = !in_chan.last_item || (n_cl == 4'd8);

  // next stripe word after lane idx: buffered words then the current word
  always_comb begin
    unique case (idx_r)
      2'd0:    word_next = pend_r[1];
      2'd1:    word_next = pend_r[2];
      default: word_next = data_r;
    endcase
  end

  // lanes are seeded on the fly the first time a stripe lands
  assign lane_base = stripe_seen_r ? acc_r[idx_r] : xxh_pkg::lane_init(seed_r, idx_r);
  assign rot_res31 = xxh_pkg::rotl64(mul_rsp.res, 6'd31);
  assign hx        = h_r ^ mul_rsp.res;

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    pend_nxt        = pend_r;
    pend_cnt_nxt    = pend_cnt_r;
    msg_len_nxt     = msg_len_r;
    stripe_seen_nxt = stripe_seen_r;
    data_nxt        = data_r;
    last_nxt        = last_r;
    rem_nxt         = rem_r;
    idx_nxt         = idx_r;
    h_nxt           = h_r;
    out_hash_nxt    = out_hash_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    mul_req         = '0;

    unique case (state_r)
      xxh_pkg::ST_IDLE: begin
        if (in_fire) begin
          data_nxt = in_chan.data_word;
          last_nxt = in_chan.last_item;
          if (full_word) begin
            msg_len_nxt = msg_len_r + 64'd8;
            rem_nxt     = 3'd0;
            if (pend_cnt_r != 2'd3) begin
              // buffer the word until the stripe is complete
              pend_nxt[pend_cnt_r] = in_chan.data_word;
              pend_cnt_nxt         = pend_cnt_r + 2'd1;
              state_nxt = in_chan.last_item ? xxh_pkg::ST_FIN : xxh_pkg::ST_IDLE;
            end else begin
              // fourth word closes a stripe: lane 0 round first
              idx_nxt       = 2'd0;
              mul_req.start = 1'b1;
              mul_req.a     = pend_r[0];
              mul_req.b     = xxh_pkg::PRIME2;
              state_nxt     = xxh_pkg::ST_R_A;
            end
          end else begin
            msg_len_nxt = msg_len_r + {60'h0, n_cl};
            rem_nxt     = n_cl[2:0];
            state_nxt   = xxh_pkg::ST_FIN;
          end
        end
      end

      // lane round: acc = rotl(acc + w*P2, 31) * P1
      xxh_pkg::ST_R_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xxh_pkg::rotl64(lane_base + mul_rsp.res, 6'd31);
          mul_req.b     = xxh_pkg::PRIME1;
          state_nxt     = xxh_pkg::ST_R_B;
        end
      end

      xxh_pkg::ST_R_B: begin
        if (mul_rsp.done) begin
          acc_nxt[idx_r] = mul_rsp.res;
          if (idx_r == 2'd3) begin
            pend_cnt_nxt    = 2'd0;
            stripe_seen_nxt = 1'b1;
            state_nxt       = last_r ? xxh_pkg::ST_FIN : xxh_pkg::ST_IDLE;
          end else begin
            idx_nxt       = idx_r + 2'd1;
            mul_req.start = 1'b1;
            mul_req.a     = word_next;
            mul_req.b     = xxh_pkg::PRIME2;
            state_nxt     = xxh_pkg::ST_R_A;
          end
        end
      end

      // finalization start: lane merge for long messages, seed start for short ones
      xxh_pkg::ST_FIN: begin
        if (stripe_seen_r) begin
          h_nxt     = xxh_pkg::rotl64(acc_r[0], 6'd1);
          idx_nxt   = 2'd1;
          state_nxt = xxh_pkg::ST_MSUM;
        end else begin
          h_nxt     = seed_r + xxh_pkg::PRIME5;
          state_nxt = xxh_pkg::ST_LEN;
        end
      end

      xxh_pkg::ST_MSUM: begin
        unique case (idx_r)
          2'd1:    h_nxt = h_r + xxh_pkg::rotl64(acc_r[1], 6'd7);
          2'd2:    h_nxt = h_r + xxh_pkg::rotl64(acc_r[2], 6'd12);
          default: h_nxt = h_r + xxh_pkg::rotl64(acc_r[3], 6'd18);
        endcase
        if (idx_r == 2'd3) begin
          idx_nxt       = 2'd0;
          mul_req.start = 1'b1;
          mul_req.a     = acc_r[0];
          mul_req.b     = xxh_pkg::PRIME2;
          state_nxt     = xxh_pkg::ST_M_A;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      // merge: h ^= round(0, v); h = h*P1 + P4
      xxh_pkg::ST_M_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = rot_res31;
          mul_req.b     = xxh_pkg::PRIME1;
          state_nxt     = xxh_pkg::ST_M_B;
        end
      end

      xxh_pkg::ST_M_B: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = hx;
          mul_req.b     = xxh_pkg::PRIME1;
          state_nxt     = xxh_pkg::ST_M_C;
        end
      end

      xxh_pkg::ST_M_C: begin
        if (mul_rsp.done) begin
          h_nxt = mul_rsp.res + xxh_pkg::PRIME4;
          if (idx_r == 2'd3) begin
            state_nxt = xxh_pkg::ST_LEN;
          end else begin
            idx_nxt       = idx_r + 2'd1;
            mul_req.start = 1'b1;
            mul_req.a     = acc_r[idx_r + 2'd1];
            mul_req.b     = xxh_pkg::PRIME2;
            state_nxt     = xxh_pkg::ST_M_A;
          end
        end
      end

      xxh_pkg::ST_LEN: begin
        h_nxt = h_r + msg_len_r;
        if (pend_cnt_r != 2'd0) begin
          idx_nxt       = 2'd0;
          mul_req.start = 1'b1;
          mul_req.a     = pend_r[0];
          mul_req.b     = xxh_pkg::PRIME2;
          state_nxt     = xxh_pkg::ST_P_A;
        end else begin
          state_nxt = xxh_pkg::ST_TAIL;
        end
      end

      // buffered full words: h ^= round(0, w); h = rotl(h, 27)*P1 + P4
      xxh_pkg::ST_P_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = rot_res31;
          mul_req.b     = xxh_pkg::PRIME1;
          state_nxt     = xxh_pkg::ST_P_B;
        end
      end

      xxh_pkg::ST_P_B: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xxh_pkg::rotl64(hx, 6'd27);
          mul_req.b     = xxh_pkg::PRIME1;
          state_nxt     = xxh_pkg::ST_P_C;
        end
      end

      xxh_pkg::ST_P_C: begin
        if (mul_rsp.done) begin
          h_nxt = mul_rsp.res + xxh_pkg::PRIME4;
          if (idx_r + 2'd1 == pend_cnt_r) begin
            state_nxt = xxh_pkg::ST_TAIL;
          end else begin
            idx_nxt       = idx_r + 2'd1;
            mul_req.start = 1'b1;
            mul_req.a     = word_next;
            mul_req.b     = xxh_pkg::PRIME2;
            state_nxt     = xxh_pkg::ST_P_A;
          end
        end
      end

      // tail dispatch: 4-byte chunk, then single bytes, then avalanche
      xxh_pkg::ST_TAIL: begin
        mul_req.start = 1'b1;
        priority if (rem_r >= 3'd4) begin
          mul_req.a = {32'h0, data_r[31:0]};
          mul_req.b = xxh_pkg::PRIME1;
          state_nxt = xxh_pkg::ST_T4_A;
        end else if (rem_r != 3'd0) begin
          mul_req.a = {56'h0, data_r[7:0]};
          mul_req.b = xxh_pkg::PRIME5;
          state_nxt = xxh_pkg::ST_T1_A;
        end else begin
          mul_req.a = h_r ^ (h_r >> 33);
          mul_req.b = xxh_pkg::PRIME2;
          state_nxt = xxh_pkg::ST_AV_A;
        end
      end

      xxh_pkg::ST_T4_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xxh_pkg::rotl64(hx, 6'd23);
          mul_req.b     = xxh_pkg::PRIME2;
          state_nxt     = xxh_pkg::ST_T4_B;
        end
      end

      xxh_pkg::ST_T4_B: begin
        if (mul_rsp.done) begin
          h_nxt     = mul_rsp.res + xxh_pkg::PRIME3;
          data_nxt  = data_r >> 32;
          rem_nxt   = rem_r - 3'd4;
          state_nxt = xxh_pkg::ST_TAIL;
        end
      end

      xxh_pkg::ST_T1_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xxh_pkg::rotl64(hx, 6'd11);
          mul_req.b     = xxh_pkg::PRIME1;
          state_nxt     = xxh_pkg::ST_T1_B;
        end
      end

      xxh_pkg::ST_T1_B: begin
        if (mul_rsp.done) begin
          h_nxt     = mul_rsp.res;
          data_nxt  = data_r >> 8;
          rem_nxt   = rem_r - 3'd1;
          state_nxt = xxh_pkg::ST_TAIL;
        end
      end

      // avalanche
      xxh_pkg::ST_AV_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.res ^ (mul_rsp.res >> 29);
          mul_req.b     = xxh_pkg::PRIME3;
          state_nxt     = xxh_pkg::ST_AV_B;
        end
      end

      xxh_pkg::ST_AV_B: begin
        if (mul_rsp.done) begin
          h_nxt     = mul_rsp.res ^ (mul_rsp.res >> 32);
          state_nxt = xxh_pkg::ST_EMIT;
        end
      end

      // hand the hash to the output register once it is free, then clear the message
      xxh_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_hash_nxt    = h_r;
          pend_cnt_nxt    = 2'd0;
          msg_len_nxt     = 64'd0;
          stripe_seen_nxt = 1'b0;
          state_nxt       = xxh_pkg::ST_IDLE;
        end
      end

      default: state_nxt = xxh_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= xxh_pkg::ST_IDLE;
      seed_r        <= 64'd0;
      pend_cnt_r    <= 2'd0;
      msg_len_r     <= 64'd0;
      stripe_seen_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pend_cnt_r    <= pend_cnt_nxt;
      msg_len_r     <= msg_len_nxt;
      stripe_seen_r <= stripe_seen_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    pend_r     <= pend_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    h_r        <= h_nxt;
    out_hash_r <= out_hash_nxt;
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r != xxh_pkg::ST_IDLE && state_r != xxh_pkg::ST_FIN &&
                      state_r != xxh_pkg::ST_MSUM && state_r != xxh_pkg::ST_LEN &&
                      state_r != xxh_pkg::ST_TAIL && state_r != xxh_pkg::ST_EMIT))
    else $error("multiply result arrived with no step waiting for it");

  a_stripe_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xxh_pkg::ST_R_B && mul_rsp.done && idx_r == 2'd3)
      |=> (stripe_seen_r && pend_cnt_r == 2'd0))
    else $error("stripe absorbed without updating the stripe state");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xxh_pkg::ST_EMIT && state_nxt == xxh_pkg::ST_IDLE)
      |=> (out_valid_r && pend_cnt_r == 2'd0 && msg_len_r == 64'd0 && !stripe_seen_r))
    else $error("message state not cleared after hash transaction");

endmodule
